/* design/rle_run_to_line_commands_defines.svh */
// Assertion macros shared by the design files.
// Each macro places a labeled concurrent assertion on the rising edge of
// clk, disabled while rst_n is low. The macros are empty in synthesis.
`ifndef RLE_RUN_TO_LINE_COMMANDS_DEFINES_SVH
`define RLE_RUN_TO_LINE_COMMANDS_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge.
`define RLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define RLC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RLC_ASSERT(label, clk, rst_n, prop, msg)
`define RLC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/rlc_pkg.sv */
package rlc_pkg;

    // Field widths
    localparam int COUNT_BITS     = 8;
    localparam int COLOR_BITS     = 8;
    localparam int COL_BITS       = 10;
    localparam int ROW_BITS       = 20;
    localparam int RGB565_BITS    = 16;
    localparam int CFG_WIDTH_BITS = 11;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_ENABLE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_FIRST_ROW = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_END_ROW   = 3'd3;

    // Register reset values
    localparam logic [CFG_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 11'd240;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CFG_WIDTH_BITS-1:0] image_width;
        logic                      window_enable;
        logic [ROW_BITS-1:0]       window_first_row;
        logic [ROW_BITS-1:0]       window_end_row;
    } cfg_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_EMIT
    } back_state_t;

    // RGB332 to RGB565: each channel scaled to 8 bits (c*255/max, truncated),
    // then cut to 5/6/5 bits
    function automatic logic [RGB565_BITS-1:0] rgb332_to_565(input logic [COLOR_BITS-1:0] c);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        unique case (c[7:5])
            3'd0:    r5 = 5'd0;
            3'd1:    r5 = 5'd4;
            3'd2:    r5 = 5'd9;
            3'd3:    r5 = 5'd13;
            3'd4:    r5 = 5'd18;
            3'd5:    r5 = 5'd22;
            3'd6:    r5 = 5'd27;
            default: r5 = 5'd31;
        endcase
        unique case (c[4:2])
            3'd0:    g6 = 6'd0;
            3'd1:    g6 = 6'd9;
            3'd2:    g6 = 6'd18;
            3'd3:    g6 = 6'd27;
            3'd4:    g6 = 6'd36;
            3'd5:    g6 = 6'd45;
            3'd6:    g6 = 6'd54;
            default: g6 = 6'd63;
        endcase
        unique case (c[1:0])
            2'd0:    b5 = 5'd0;
            2'd1:    b5 = 5'd10;
            2'd2:    b5 = 5'd21;
            default: b5 = 5'd31;
        endcase
        return {r5, g6, b5};
    endfunction

endpackage

/* design/rlc_front.sv */
`include "rle_run_to_line_commands_defines.svh"

module rlc_front
    import rlc_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int QDATA_BITS = INDEX_BITS + COUNT_BITS + RGB565_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [COUNT_BITS-1:0]   run_count,
    input  logic [COLOR_BITS-1:0]   color_code,
    input  logic                    last_run,
    input  logic                    q_full,
    output logic                    push,
    output logic [QDATA_BITS-1:0]   push_data
);

    logic [INDEX_BITS-1:0] index_reg;
    logic [INDEX_BITS-1:0] index_next;
    logic [INDEX_BITS:0]   sum;
    logic                  accept;

    assign accept = in_valid && !q_full;
    assign sum    = {1'b0, index_reg} + {{(INDEX_BITS + 1 - COUNT_BITS){1'b0}}, run_count};

    // Running pixel index: saturating advance, cleared after the last run
    always_comb
    begin
        priority if (!accept)
            index_next = index_reg;
        else if (last_run)
            index_next = '0;
        else if (sum[INDEX_BITS])
            index_next = '1;
        else
            index_next = sum[INDEX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= '0;
        else
            index_reg <= index_next;
    end

    // Command: start index, length, converted color
    assign push      = accept;
    assign push_data = {index_reg, run_count, rgb332_to_565(color_code)};

    `RLC_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && last_run, index_reg == '0, "index not cleared after last run")
    `RLC_ASSERT_NEXT(a_saturate, clk, rst_n, accept && !last_run && sum[INDEX_BITS], index_reg == '1, "index did not saturate")
    `RLC_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !q_full, "push into full queue")

endmodule

/* design/rlc_queue.sv */
`include "rle_run_to_line_commands_defines.svh"

module rlc_queue
    import rlc_pkg::*;
#(
    parameter int DATA_BITS = 44
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_BITS-1:0]  push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  q_valid,
    output logic [DATA_BITS-1:0]  q_data
);

    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `RLC_ASSERT(a_count_range, clk, rst_n, count_reg <= COUNT_W'(QUEUE_DEPTH), "queue count overflow")
    `RLC_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, q_valid, "pop from empty queue")
    `RLC_ASSERT_NEXT(a_count_up, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "count did not follow push")

endmodule

/* design/rlc_back.sv */
`include "rle_run_to_line_commands_defines.svh"

module rlc_back
    import rlc_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int MAX_WIDTH  = 1024,
    parameter int QDATA_BITS = INDEX_BITS + COUNT_BITS + RGB565_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_valid,
    input  logic [QDATA_BITS-1:0]    q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [COL_BITS-1:0]      start_column,
    output logic [ROW_BITS-1:0]      start_row,
    output logic [COUNT_BITS-1:0]    line_length,
    output logic [RGB565_BITS-1:0]   color565
);

    // Two quotient bits per cycle
    localparam int DIV_STEPS = (INDEX_BITS + 1) / 2;
    localparam int PAD_BITS  = 2 * DIV_STEPS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);
    localparam int EXT_BITS  = ROW_BITS + PAD_BITS;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [STEP_BITS-1:0]      step_reg;
    logic [STEP_BITS-1:0]      step_next;
    logic [PAD_BITS-1:0]       dividend_reg;
    logic [PAD_BITS-1:0]       quot_reg;
    logic [CFG_WIDTH_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0]     count_reg;
    logic [RGB565_BITS-1:0]    color_reg;
    logic                      out_valid_reg;
    logic [COL_BITS-1:0]       column_reg;
    logic [ROW_BITS-1:0]       row_reg;
    logic [COUNT_BITS-1:0]     length_reg;
    logic [RGB565_BITS-1:0]    color565_reg;

    logic [CFG_WIDTH_BITS-1:0] width_eff;
    logic [CFG_WIDTH_BITS:0]   step_a;
    logic [CFG_WIDTH_BITS:0]   step_b;
    logic [INDEX_BITS:0]       index_ext;
    logic [EXT_BITS-1:0]       row_ext;
    logic [EXT_BITS-1:0]       first_ext;
    logic [EXT_BITS-1:0]       end_ext;
    logic                      emit;
    logic                      out_free;
    logic                      load;
    logic                      out_load;
    logic                      emit_done;

    // One restoring step: remainder stays below the divisor
    function automatic logic [CFG_WIDTH_BITS:0] div_step(
        input logic [CFG_WIDTH_BITS-1:0] r,
        input logic                      b,
        input logic [CFG_WIDTH_BITS-1:0] d
    );
        logic [CFG_WIDTH_BITS:0] t;
        logic [CFG_WIDTH_BITS:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {1'b1, diff[CFG_WIDTH_BITS-1:0]};
        else
            return {1'b0, t[CFG_WIDTH_BITS-1:0]};
    endfunction

    // Effective width: zero reads as one, clamp to MAX_WIDTH
    always_comb
    begin
        priority if (cfg.image_width == '0)
            width_eff = CFG_WIDTH_BITS'(1);
        else if (32'(cfg.image_width) > MAX_WIDTH)
            width_eff = CFG_WIDTH_BITS'(MAX_WIDTH);
        else
            width_eff = cfg.image_width;
    end

    // Two divider steps this cycle
    assign step_a = div_step(rem_reg, dividend_reg[PAD_BITS-1], width_eff);
    assign step_b = div_step(step_a[CFG_WIDTH_BITS-1:0], dividend_reg[PAD_BITS-2], width_eff);

    // Row window filter on the full quotient
    assign index_ext = {1'b0, q_data[QDATA_BITS-1 -: INDEX_BITS]};
    assign row_ext   = {{ROW_BITS{1'b0}}, quot_reg};
    assign first_ext = {{PAD_BITS{1'b0}}, cfg.window_first_row};
    assign end_ext   = {{PAD_BITS{1'b0}}, cfg.window_end_row};
    assign emit      = !cfg.window_enable || ((row_ext >= first_ext) && (row_ext < end_ext));
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (q_valid)
                    state_next = BACK_DIVIDE;
            end
            BACK_DIVIDE:
            begin
                if (step_reg == '0)
                    state_next = BACK_EMIT;
            end
            BACK_EMIT:
            begin
                if (!emit || out_free)
                    state_next = q_valid ? BACK_DIVIDE : BACK_IDLE;
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        load      = 1'b0;
        out_load  = 1'b0;
        emit_done = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                load = q_valid;
            end
            BACK_DIVIDE:
            begin
                load = 1'b0;
            end
            BACK_EMIT:
            begin
                emit_done = !emit || out_free;
                out_load  = emit && out_free;
                load      = emit_done && q_valid;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign q_pop = load;

    always_comb
    begin
        if (load)
            step_next = STEP_BITS'(DIV_STEPS - 1);
        else if (state_reg == BACK_DIVIDE && step_reg != '0)
            step_next = step_reg - 1'b1;
        else
            step_next = step_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dividend_reg <= index_ext[PAD_BITS-1:0];
            quot_reg     <= '0;
            rem_reg      <= '0;
            count_reg    <= q_data[RGB565_BITS +: COUNT_BITS];
            color_reg    <= q_data[RGB565_BITS-1:0];
        end
        else if (state_reg == BACK_DIVIDE)
        begin
            dividend_reg <= {dividend_reg[PAD_BITS-3:0], 2'b00};
            quot_reg     <= {quot_reg[PAD_BITS-3:0], step_a[CFG_WIDTH_BITS],
                             step_b[CFG_WIDTH_BITS]};
            rem_reg      <= step_b[CFG_WIDTH_BITS-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            column_reg   <= rem_reg[COL_BITS-1:0];
            row_reg      <= row_ext[ROW_BITS-1:0];
            length_reg   <= count_reg;
            color565_reg <= color_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign start_column = column_reg;
    assign start_row    = row_reg;
    assign line_length  = length_reg;
    assign color565     = color565_reg;

    `RLC_ASSERT_IMPL(a_load_state, clk, rst_n, load, state_reg != BACK_DIVIDE, "load during divide")
    `RLC_ASSERT_IMPL(a_rem_bound, clk, rst_n, state_reg == BACK_DIVIDE, rem_reg < width_eff, "remainder not below width")
    `RLC_ASSERT_NEXT(a_emit_shows, clk, rst_n, out_load, out_valid_reg, "emitted beat not presented")

endmodule

/* design/rle_run_to_line_commands.sv */
// Run-length decoder to horizontal-line commands. Each input beat is one run
// (pixel count, RGB332 color, last-run flag); each output beat is one line
// command (start column, start row, length, RGB565 color) for runs whose start
// row passes the optional row window. Column and row come from the running
// pixel index divided by the configured image width in a radix-4 restoring
// divider, two quotient bits per cycle. A two-beat command queue sits in front
// of the divider and the result waits in an output register, so input and
// output stall independently. The pixel index saturates at its maximum and
// returns to zero after a last-run beat. Write the configuration registers
// only while the block is idle.
module rle_run_to_line_commands
    import rlc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int INDEX_BITS = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Run input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [COUNT_BITS-1:0]     run_count,
    input  logic [COLOR_BITS-1:0]     color_code,
    input  logic                      last_run,
    // Line command output
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COL_BITS-1:0]       start_column,
    output logic [ROW_BITS-1:0]       start_row,
    output logic [COUNT_BITS-1:0]     line_length,
    output logic [RGB565_BITS-1:0]    color565
);

    localparam int QDATA_BITS = INDEX_BITS + COUNT_BITS + RGB565_BITS;

    cfg_t                  cfg_reg;
    logic                  push;
    logic [QDATA_BITS-1:0] push_data;
    logic                  q_full;
    logic                  q_valid;
    logic [QDATA_BITS-1:0] q_data;
    logic                  q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= IMAGE_WIDTH_RESET;
            cfg_reg.window_enable    <= 1'b0;
            cfg_reg.window_first_row <= '0;
            cfg_reg.window_end_row   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:      cfg_reg.image_width      <= cfg_data[CFG_WIDTH_BITS-1:0];
                REG_WINDOW_ENABLE:    cfg_reg.window_enable    <= cfg_data[0];
                REG_WINDOW_FIRST_ROW: cfg_reg.window_first_row <= cfg_data[ROW_BITS-1:0];
                REG_WINDOW_END_ROW:   cfg_reg.window_end_row   <= cfg_data[ROW_BITS-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;

    rlc_front #(
        .INDEX_BITS (INDEX_BITS),
        .QDATA_BITS (QDATA_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .run_count  (run_count),
        .color_code (color_code),
        .last_run   (last_run),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    rlc_queue #(
        .DATA_BITS (QDATA_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    rlc_back #(
        .INDEX_BITS (INDEX_BITS),
        .MAX_WIDTH  (MAX_WIDTH),
        .QDATA_BITS (QDATA_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .start_column (start_column),
        .start_row    (start_row),
        .line_length  (line_length),
        .color565     (color565)
    );

endmodule
